// ===== sv/tdpb_pkg.sv =====
// shared types and constants of the tail drop packet buffer
`default_nettype none

package tdpb_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DurW  = 16;
  localparam int unsigned SizeW = 5;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(16);

  typedef struct packed {
    logic [TimeW-1:0] arrival_time;
    logic [DurW-1:0]  duration;
  } item_t;

  typedef struct packed {
    logic             dropped;
    logic [TimeW-1:0] start_time;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DECIDE
  } eng_state_e;

endpackage

`default_nettype wire

// ===== sv/tdpb_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module tdpb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/tdpb_fifo.sv =====
// small register queue used between the front and back of the buffer
`default_nettype none

module tdpb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o
);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tdpb_engine.sv =====
// back end: retires finished packets, decides drop or start, keeps the finish queue
`default_nettype none

module tdpb_engine #(
  parameter int unsigned MaxDepth = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [tdpb_pkg::SizeW-1:0]     buffer_size_i,
  input  wire logic                           item_valid_i,
  input  wire tdpb_pkg::item_t                item_i,
  output logic                                item_pop_o,
  input  wire logic                           res_full_i,
  output logic                                res_push_o,
  output tdpb_pkg::result_t                   res_o
);

  localparam int unsigned AddrW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int unsigned CntW  = $clog2(MaxDepth + 1);
  localparam int unsigned SumW  = CntW + 1;
  localparam int unsigned CapW  = (CntW > tdpb_pkg::SizeW) ? CntW : tdpb_pkg::SizeW;
  localparam int unsigned TW    = tdpb_pkg::TimeW;

  tdpb_pkg::eng_state_e state_q, state_d;
  tdpb_pkg::item_t      item_q, item_d;
  logic [AddrW-1:0]     head_q, head_d, head_nxt, tail;
  logic [CntW-1:0]      count_q, count_d;
  logic [TW-1:0]        last_finish_q, last_finish_d;

  logic                 rd_en;
  logic [AddrW-1:0]     rd_addr;
  logic [TW-1:0]        rd_data;
  logic                 wr_en;
  logic [TW-1:0]        fin;

  logic [SumW-1:0]      tail_sum;
  logic [CapW-1:0]      size_ext, cap;
  logic [TW-1:0]        start;
  logic [TW:0]          fin_sum;
  logic                 is_full;

  // circular finish queue, oldest entry at head
  tdpb_ram #(
    .Width (TW),
    .Depth (MaxDepth)
  ) u_finish_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail),
    .wdata_i (fin),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign head_nxt = (head_q == AddrW'(MaxDepth - 1)) ? '0 : head_q + AddrW'(1);
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail     = (tail_sum >= SumW'(MaxDepth)) ? AddrW'(tail_sum - SumW'(MaxDepth))
                                                  : AddrW'(tail_sum);

  // buffer size clamped to 1..MaxDepth
  assign size_ext = CapW'(buffer_size_i);
  always_comb begin
    cap = size_ext;
    if (size_ext == '0) begin
      cap = CapW'(1);
    end else if (size_ext > CapW'(MaxDepth)) begin
      cap = CapW'(MaxDepth);
    end
  end
  assign is_full = (CapW'(count_q) >= cap);

  assign start   = (item_q.arrival_time > last_finish_q) ? item_q.arrival_time
                                                          : last_finish_q;
  assign fin_sum = {1'b0, start} + (TW + 1)'(item_q.duration);
  assign fin     = fin_sum[TW] ? '1 : fin_sum[TW-1:0];

  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    head_d        = head_q;
    count_d       = count_q;
    last_finish_d = last_finish_q;
    item_pop_o    = 1'b0;
    res_push_o    = 1'b0;
    res_o         = '0;
    rd_en         = 1'b0;
    rd_addr       = head_q;
    wr_en         = 1'b0;
    case (state_q)
      tdpb_pkg::ST_IDLE: begin
        // output slot is reserved here, so the result push never stalls
        if (item_valid_i && !res_full_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          state_d    = tdpb_pkg::ST_READ;
        end
      end
      tdpb_pkg::ST_READ: begin
        if (count_q == '0) begin
          state_d = tdpb_pkg::ST_DECIDE;
        end else begin
          rd_en   = 1'b1;
          state_d = tdpb_pkg::ST_CHECK;
        end
      end
      tdpb_pkg::ST_CHECK: begin
        // one head entry retired per cycle, next head read in the same cycle
        if (rd_data <= item_q.arrival_time) begin
          head_d  = head_nxt;
          count_d = count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            state_d = tdpb_pkg::ST_DECIDE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_nxt;
          end
        end else begin
          state_d = tdpb_pkg::ST_DECIDE;
        end
      end
      tdpb_pkg::ST_DECIDE: begin
        res_push_o = 1'b1;
        if (is_full) begin
          res_o.dropped = 1'b1;
        end else begin
          res_o.start_time = start;
          wr_en            = 1'b1;
          count_d          = count_q + CntW'(1);
          last_finish_d    = fin;
        end
        state_d = tdpb_pkg::ST_IDLE;
      end
      default: begin
        state_d = tdpb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= tdpb_pkg::ST_IDLE;
      head_q        <= '0;
      count_q       <= '0;
      last_finish_q <= '0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      count_q       <= count_d;
      last_finish_q <= last_finish_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

`default_nettype wire

// ===== sv/tail_drop_packet_buffer_unit.sv =====
// Tail drop packet buffer with one server, modeled per packet.
// Input side is a queue: drive arrival_time_i and duration_i with push high;
// the packet transfers on a clock edge where push is high and full is low.
// Result side is a queue too: dropped_o and start_time_o hold the oldest
// result while empty is low; it transfers on an edge where pop is high.
// Each packet yields one result, in arrival order.
// A two entry input queue feeds a back end that walks the finish time memory
// one entry per cycle from its head, retiring every finish at or before the
// arrival, then drops or starts the packet. The back end steps through idle,
// where it takes the packet, then read, a check state for each head entry
// examined, and decide; the registered memory read port is why the read
// state comes before the checks. The user must write buffer_size_i (reset 16)
// through buffer_size_we_i only while the block is idle; the block itself
// does not enforce this. Reset empties both queues and the finish queue
// and clears the last finish time. A stalled receiver fills the result
// queue; the back end then waits and the input queue fills until full
// rises.
`default_nettype none

module tail_drop_packet_buffer_unit #(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        buffer_size_we_i,
  input  wire logic [tdpb_pkg::SizeW-1:0]  buffer_size_i,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [tdpb_pkg::TimeW-1:0]  arrival_time_i,
  input  wire logic [tdpb_pkg::DurW-1:0]   duration_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             dropped_o,
  output logic      [tdpb_pkg::TimeW-1:0]  start_time_o
);

  localparam int unsigned ItemW = $bits(tdpb_pkg::item_t);
  localparam int unsigned ResW  = $bits(tdpb_pkg::result_t);

  logic [tdpb_pkg::SizeW-1:0] buffer_size_q;
  tdpb_pkg::item_t            in_item, eng_item;
  tdpb_pkg::result_t          eng_res, out_res;
  logic                       in_empty, eng_pop, eng_push, res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= tdpb_pkg::SizeReset;
    end else if (buffer_size_we_i) begin
      buffer_size_q <= buffer_size_i;
    end
  end

  assign in_item.arrival_time = arrival_time_i;
  assign in_item.duration     = duration_i;

  tdpb_fifo #(
    .Width (ItemW),
    .Depth (2)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_item),
    .full_o  (full),
    .pop_i   (eng_pop),
    .rdata_o (eng_item),
    .empty_o (in_empty)
  );

  tdpb_engine #(
    .MaxDepth (MAX_DEPTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .buffer_size_i (buffer_size_q),
    .item_valid_i  (!in_empty),
    .item_i        (eng_item),
    .item_pop_o    (eng_pop),
    .res_full_i    (res_full),
    .res_push_o    (eng_push),
    .res_o         (eng_res)
  );

  tdpb_fifo #(
    .Width (ResW),
    .Depth (2)
  ) u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (eng_push),
    .wdata_i (eng_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign dropped_o    = out_res.dropped;
  assign start_time_o = out_res.start_time;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the tail drop packet buffer: queue handshakes, scoreboard check
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Depth = 16;
  localparam int unsigned SettleCycles = 30;

  // predicts the drop decision and start time of each accepted packet
  class tail_drop_scoreboard;
    logic [tdpb_pkg::TimeW-1:0] finish_times[$];
    logic [tdpb_pkg::TimeW-1:0] last_finish;
    int unsigned                capacity;
    tdpb_pkg::result_t          verdict_q[$];
    int unsigned                mismatches;
    int unsigned                checked;

    function new();
      last_finish = '0;
      capacity    = Depth;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void set_size(logic [tdpb_pkg::SizeW-1:0] v);
      int unsigned s;
      s = 32'(v);
      if (s == 0) capacity = 1;
      else if (s > Depth) capacity = Depth;
      else capacity = s;
    endfunction

    function void admit_packet(logic [tdpb_pkg::TimeW-1:0] arrival,
                               logic [tdpb_pkg::DurW-1:0] dur);
      tdpb_pkg::result_t          r;
      logic [tdpb_pkg::TimeW:0]   fin;
      logic [tdpb_pkg::TimeW-1:0] st;
      // finish times are kept in order, so retire from the head
      while (finish_times.size() > 0 && finish_times[0] <= arrival)
        void'(finish_times.pop_front());
      if (finish_times.size() >= capacity) begin
        r.dropped    = 1'b1;
        r.start_time = '0;
      end else begin
        st  = (arrival > last_finish) ? arrival : last_finish;
        fin = {1'b0, st} + (tdpb_pkg::TimeW + 1)'(dur);
        if (fin[tdpb_pkg::TimeW]) fin[tdpb_pkg::TimeW-1:0] = '1;
        finish_times = {finish_times, fin[tdpb_pkg::TimeW-1:0]};
        last_finish  = fin[tdpb_pkg::TimeW-1:0];
        r.dropped    = 1'b0;
        r.start_time = st;
      end
      verdict_q = {verdict_q, r};
    endfunction

    function void check_verdict(logic dropped, logic [tdpb_pkg::TimeW-1:0] start);
      tdpb_pkg::result_t want;
      checked++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: dropped=%b start=%h",
                   $time, dropped, start);
        return;
      end
      want = verdict_q.pop_front();
      if (dropped !== want.dropped || start !== want.start_time) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d: expected dropped=%b start=%h, got dropped=%b start=%h",
                   $time, checked, want.dropped, want.start_time, dropped, start);
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       buffer_size_we_i;
  logic [tdpb_pkg::SizeW-1:0] buffer_size_i;
  logic                       push;
  logic                       full;
  logic [tdpb_pkg::TimeW-1:0] arrival_time_i;
  logic [tdpb_pkg::DurW-1:0]  duration_i;
  logic                       empty;
  logic                       pop;
  logic                       dropped_o;
  logic [tdpb_pkg::TimeW-1:0] start_time_o;

  tail_drop_scoreboard sb;
  bit                  no_idle;

  tail_drop_packet_buffer_unit #(.MAX_DEPTH(Depth)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .buffer_size_we_i(buffer_size_we_i),
    .buffer_size_i   (buffer_size_i),
    .push            (push),
    .full            (full),
    .arrival_time_i  (arrival_time_i),
    .duration_i      (duration_i),
    .empty           (empty),
    .pop             (pop),
    .dropped_o       (dropped_o),
    .start_time_o    (start_time_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL tail_drop_packet_buffer_unit");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(30, 80);
  endfunction

  // push stays high between back-to-back packets
  task automatic send_pkt(input logic [tdpb_pkg::TimeW-1:0] arr,
                          input logic [tdpb_pkg::DurW-1:0] dur);
    if (!no_idle && $urandom_range(0, 99) < 20) begin
      push <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    push           <= 1'b1;
    arrival_time_i <= arr;
    duration_i     <= dur;
    do @(posedge clk_i); while (full !== 1'b0);
    sb.admit_packet(arr, dur);
  endtask

  // wait until every expected result is out and the back end has gone quiet
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [tdpb_pkg::SizeW-1:0] v);
    buffer_size_we_i <= 1'b1;
    buffer_size_i    <= v;
    @(posedge clk_i);
    buffer_size_we_i <= 1'b0;
    sb.set_size(v);
  endtask

  initial begin : result_side
    int unsigned stall_left;
    bit          long_hold_done;
    stall_left     = 0;
    long_hold_done = 0;
    pop            = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_verdict(dropped_o, start_time_o);
      // one long hold-off so the buffer backs up and full rises
      if (!long_hold_done && sb.checked >= 400) begin
        stall_left     = 500;
        long_hold_done = 1;
      end else if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 15) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [tdpb_pkg::TimeW-1:0] cur_time;
    logic [tdpb_pkg::TimeW-1:0] arr;
    logic [tdpb_pkg::DurW-1:0]  dur;
    logic [tdpb_pkg::SizeW-1:0] sz;
    int unsigned                r;
    bit                         heavy;
    sb               = new();
    no_idle          = 0;
    rst_ni           = 1'b0;
    buffer_size_we_i = 1'b0;
    buffer_size_i    = '0;
    push             = 1'b0;
    arrival_time_i   = '0;
    duration_i       = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset size: fill all sixteen slots, the next one is dropped
    send_pkt(32'd0, 16'd0);
    send_pkt(32'd0, 16'd100);
    repeat (17) send_pkt(32'd200, 16'd1000);

    // shrink below the fill: drops until retirements make room
    settle();
    write_size(5'd4);
    send_pkt(32'd1200, 16'd1);
    send_pkt(32'd12200, 16'd1);
    send_pkt(32'd13200, 16'd1);

    // size zero acts as one
    settle();
    write_size(5'd0);
    send_pkt(32'd13200, 16'd5);

    cur_time = 32'd20000;
    for (int phase = 0; phase < 12; phase++) begin
      settle();
      case (phase)
        0: sz = 5'd3;
        1: sz = 5'd1;
        2: sz = 5'd16;
        3: sz = 5'd0;
        4: sz = 5'd31;
        5: sz = 5'd2;
        6: sz = 5'd8;
        7: sz = 5'd17;
        default: sz = tdpb_pkg::SizeW'($urandom_range(0, 31));
      endcase
      write_size(sz);
      no_idle = ($urandom_range(0, 3) == 0);
      heavy   = $urandom_range(0, 1);
      repeat (155) begin
        r = $urandom_range(0, 99);
        if (r < 3 && cur_time < 32'hE000_0000)
          cur_time += $urandom_range(0, 32'h0800_0000);
        else
          cur_time += heavy ? $urandom_range(0, 120) : $urandom_range(0, 400);
        arr = cur_time;
        if (r >= 97 && cur_time > 3000) arr = cur_time - $urandom_range(1, 3000);
        r = $urandom_range(0, 99);
        if (r < 5) dur = '0;
        else if (r < 7) dur = tdpb_pkg::DurW'($urandom());
        else dur = heavy ? tdpb_pkg::DurW'($urandom_range(50, 300))
                         : tdpb_pkg::DurW'($urandom_range(0, 150));
        send_pkt(arr, dur);
      end
    end

    // saturating finish times last, since the time line cannot come back
    settle();
    write_size(5'd31);
    no_idle = 0;
    send_pkt(32'hFFFF_FF00, 16'hFFFF);
    send_pkt(32'd10, 16'd3);
    send_pkt(32'hFFFF_FFFF, 16'd0);

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS tail_drop_packet_buffer_unit");
    end else begin
      $display("FAIL tail_drop_packet_buffer_unit");
    end
    $finish;
  end

endmodule
